FILE: rtl/fwid_pkg.sv
// Shared types and constants for the queue with indexed discard.
`default_nettype none
package fwid_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_DISCARD = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/fwid_if.sv
// Request and response channel interfaces of the queue.
`default_nettype none
interface fwid_in_if;
  import fwid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [WordW-1:0]  value;
  logic [PosW-1:0]          position;

  modport source (output valid, output operation, output value, output position, input ready);
  modport sink (input valid, input operation, input value, input position, output ready);
endinterface

interface fwid_out_if;
  import fwid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WordW-1:0]  front_value;
  logic [CountW-1:0]        count;
  logic                     is_empty;
  logic                     error;

  modport source (output valid, output front_value, output count, output is_empty,
                  output error, input ready);
  modport sink (input valid, input front_value, input count, input is_empty,
                input error, output ready);
endinterface
`default_nettype wire

FILE: rtl/fwid_cell.sv
// One storage cell of the queue chain: holds a word, loads or takes its neighbor's word.
`default_nettype none
module fwid_cell (
  input  wire logic                            clk_i,
  input  wire fwid_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [fwid_pkg::WordW-1:0]      value_i,
  input  wire logic [fwid_pkg::WordW-1:0]      next_i,
  output logic      [fwid_pkg::WordW-1:0]      data_d_o,
  output logic      [fwid_pkg::WordW-1:0]      data_q_o
);
  import fwid_pkg::*;

  logic [WordW-1:0] data_q;
  logic [WordW-1:0] data_d;

  always_comb begin
    if (ctrl_i.load) begin
      data_d = value_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_d_o = data_d;
  assign data_q_o = data_q;

endmodule
`default_nettype wire

FILE: rtl/fifo_with_indexed_discard.sv
// Top level of the bounded queue with enqueue, dequeue, discard at position and query.
// The queue takes one operation per cycle: the response appears in the output register in the
// cycle after the request transfer, and a new request is taken while the previous response
// is still waiting as long as that response is taken in the same cycle. The words sit in a
// chain of Depth cells with the front in cell 0; a dequeue or discard moves every cell at or
// behind the removed place forward by one, all together, and an enqueue loads the cell
// at the current count. A discard at a position not below the count, a dequeue on an empty
// queue and an enqueue on a full queue report an error and leave the queue unchanged.
`default_nettype none
module fifo_with_indexed_discard (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fwid_in_if.sink   in_i,
  fwid_out_if.source out_o
);
  import fwid_pkg::*;

  localparam int unsigned OccW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (OccW > PosW) ? OccW : PosW;

  logic [OccW-1:0]  occ_q, occ_d;
  logic             take;
  op_e              op;
  logic [CmpW-1:0]  occ_ext, pos_ext, rem_idx;
  logic             enq_ok, rem_ok, err;

  cell_ctrl_t       ctrl    [Depth];
  logic [WordW-1:0] cell_d  [Depth];
  logic [WordW-1:0] cell_q  [Depth];

  logic                    out_valid_q;
  logic signed [WordW-1:0] front_q;
  logic [CountW-1:0]       count_q;
  logic                    empty_q;
  logic                    err_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.operation);
  assign occ_ext    = CmpW'(occ_q);
  assign pos_ext    = CmpW'(in_i.position);

  always_comb begin
    enq_ok  = 1'b0;
    rem_ok  = 1'b0;
    err     = 1'b0;
    rem_idx = '0;
    unique case (op)
      OP_ENQUEUE: begin
        enq_ok = (occ_q != OccW'(Depth));
        err    = !enq_ok;
      end
      OP_DEQUEUE: begin
        rem_ok = (occ_q != '0);
        err    = !rem_ok;
      end
      OP_DISCARD: begin
        rem_ok  = (pos_ext < occ_ext);
        err     = !rem_ok;
        rem_idx = pos_ext;
      end
      OP_QUERY: begin
        err = 1'b0;
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (take && enq_ok) begin
      occ_d = occ_q + OccW'(1);
    end else if (take && rem_ok) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [WordW-1:0] next_word;

    if (i == Depth - 1) begin : g_last
      assign next_word = '0;
    end else begin : g_mid
      assign next_word = cell_q[i+1];
    end

    assign ctrl[i].load  = take && enq_ok && (CmpW'(i) == occ_ext);
    assign ctrl[i].shift = take && rem_ok && (CmpW'(i) >= rem_idx);

    fwid_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl[i]),
      .value_i  (in_i.value),
      .next_i   (next_word),
      .data_d_o (cell_d[i]),
      .data_q_o (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      front_q <= (occ_d != '0) ? cell_d[0] : '0;
      count_q <= CountW'(occ_d);
      empty_q <= (occ_d == '0);
      err_q   <= err;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.front_value = front_q;
  assign out_o.count       = count_q;
  assign out_o.is_empty    = empty_q;
  assign out_o.error       = err_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(Depth))
    else $error("Occupancy exceeds the queue depth.");

  a_err_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && err |=> occ_q == $past(occ_q))
    else $error("A rejected operation changed the occupancy.");

  a_enq_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && enq_ok |=> occ_q == $past(occ_q) + OccW'(1))
    else $error("An accepted enqueue did not add one entry.");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_o.valid && (out_o.is_empty == (occ_q == '0)))
    else $error("Empty flag disagrees with the occupancy.");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the queue with enqueue, dequeue, discard at position and query.
`timescale 1ns / 1ps
module testbench;
  import fwid_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned RandOps   = 650;

  typedef struct {
    logic                    hold;
    op_e                     op;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         position;
  } queue_req_t;

  typedef struct packed {
    logic signed [WordW-1:0] front_value;
    logic [CountW-1:0]       count;
    logic                    is_empty;
    logic                    error;
  } queue_status_t;

  logic clk_i;
  logic rst_ni;

  fwid_in_if  req_if ();
  fwid_out_if rsp_if ();

  fifo_with_indexed_discard dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  queue_req_t    pending_ops[$];
  queue_status_t expected_status[$];

  logic signed [WordW-1:0] words[Depth];
  int unsigned             fill;
  int unsigned             gen_fill;
  int unsigned             fails;
  int unsigned             idle_cycles;
  int unsigned             cyc;
  int unsigned             req_gap;
  int unsigned             rsp_stall;
  logic                    req_taken;

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [WordW-1:0] rand_word();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic queue_status_t queue_step(op_e op, logic signed [WordW-1:0] val,
                                               logic [PosW-1:0] pos);
    queue_status_t st;
    int unsigned   from;
    int unsigned   i;
    st.error = 1'b0;
    from = Depth;
    case (op)
      OP_ENQUEUE: begin
        if (fill >= Depth) begin
          st.error = 1'b1;
        end else begin
          words[PosW'(fill)] = val;
          fill++;
        end
      end
      OP_DEQUEUE: begin
        if (fill == 0) st.error = 1'b1;
        else from = 0;
      end
      OP_DISCARD: begin
        if (32'(pos) >= fill) st.error = 1'b1;
        else from = 32'(pos);
      end
      default: ;
    endcase
    if (from < Depth) begin
      for (i = from; i + 1 < fill; i++) words[PosW'(i)] = words[PosW'(i + 1)];
      fill--;
    end
    st.front_value = (fill != 0) ? words[0] : '0;
    st.count       = CountW'(fill);
    st.is_empty    = (fill == 0);
    return st;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (fails < 100) begin
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    end
    fails++;
  endtask

  task automatic add_op(op_e op, logic signed [WordW-1:0] val, int unsigned pos);
    queue_req_t r;
    r.hold     = 1'b0;
    r.op       = op;
    r.value    = val;
    r.position = PosW'(pos);
    pending_ops.push_back(r);
    case (op)
      OP_ENQUEUE: if (gen_fill < Depth) gen_fill++;
      OP_DEQUEUE: if (gen_fill > 0) gen_fill--;
      OP_DISCARD: if (32'(r.position) < gen_fill) gen_fill--;
      default: ;
    endcase
  endtask

  task automatic add_pause();
    queue_req_t r;
    r.hold     = 1'b1;
    r.op       = OP_QUERY;
    r.value    = '0;
    r.position = '0;
    pending_ops.push_back(r);
  endtask

  always @(negedge clk_i) begin : drive_req
    logic       drive_valid;
    queue_req_t nxt;
    drive_valid = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && !req_taken) begin
        drive_valid = 1'b1;
      end else begin
        if (req_taken && (cyc % 1000) >= 150) req_gap = pick_gap();
        if (req_gap != 0) begin
          req_gap--;
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops[0];
          if (nxt.hold) begin
            if (expected_status.size() == 0) void'(pending_ops.pop_front());
          end else begin
            drive_valid        = 1'b1;
            req_if.operation  <= nxt.op;
            req_if.value      <= nxt.value;
            req_if.position   <= nxt.position;
          end
        end
      end
    end
    req_if.valid <= drive_valid;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_stall != 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if ((cyc % 1000) >= 150 && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
    end
  end

  always @(posedge clk_i) begin : watch_queue
    queue_status_t want;
    logic          moved;
    logic          took;
    moved = 1'b0;
    took  = 1'b0;
    if (rst_ni) begin
      cyc++;
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (expected_status.size() == 0) begin
          report_mismatch("response with nothing outstanding, count", rsp_if.count, 0);
        end else begin
          want = expected_status.pop_front();
          if (rsp_if.front_value !== want.front_value) begin
            report_mismatch("front_value", rsp_if.front_value, want.front_value);
          end
          if (rsp_if.count !== want.count) begin
            report_mismatch("count", rsp_if.count, want.count);
          end
          if (rsp_if.is_empty !== want.is_empty) begin
            report_mismatch("is_empty", rsp_if.is_empty, want.is_empty);
          end
          if (rsp_if.error !== want.error) begin
            report_mismatch("error", rsp_if.error, want.error);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        took  = 1'b1;
        void'(pending_ops.pop_front());
        expected_status.push_back(queue_step(op_e'(req_if.operation), req_if.value,
                                             req_if.position));
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("** fifo_with_indexed_discard: FAILED **");
        $finish;
      end
    end
    req_taken <= took;
  end

  initial begin
    int unsigned target;
    int unsigned r;
    int unsigned k;
    int unsigned pos;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.operation = OP_QUERY;
    req_if.value = '0;
    req_if.position = '0;
    rsp_if.ready = 1'b0;
    fill = 0;
    gen_fill = 0;
    fails = 0;
    idle_cycles = 0;
    cyc = 0;
    req_gap = 0;
    rsp_stall = 0;
    req_taken = 1'b0;

    add_op(OP_QUERY, $urandom, $urandom);
    add_op(OP_DEQUEUE, $urandom, $urandom);
    add_op(OP_DISCARD, $urandom, 0);
    add_op(OP_DISCARD, $urandom, 15);
    add_op(OP_ENQUEUE, 32'sh7FFF_FFFF, $urandom);
    add_op(OP_ENQUEUE, 32'sh8000_0000, $urandom);
    add_op(OP_ENQUEUE, -32'sd1, $urandom);
    add_op(OP_ENQUEUE, 32'sd0, $urandom);
    while (gen_fill < Depth) add_op(OP_ENQUEUE, $urandom, $urandom);
    add_op(OP_ENQUEUE, $urandom, $urandom);
    add_op(OP_DISCARD, $urandom, 15);
    add_op(OP_DISCARD, $urandom, 15);
    add_op(OP_DISCARD, $urandom, 0);
    add_op(OP_DISCARD, $urandom, 7);
    add_op(OP_DEQUEUE, $urandom, $urandom);
    add_op(OP_QUERY, $urandom, $urandom);
    add_pause();

    target = Depth;
    for (k = 0; k < RandOps; k++) begin
      if (k == RandOps / 2) add_pause();
      if (gen_fill == target) begin
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = Depth;
          default: target = $urandom_range(0, Depth);
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add_op(OP_QUERY, $urandom, $urandom);
      end else if (r < 12) begin
        if (gen_fill == Depth) add_op(OP_ENQUEUE, rand_word(), $urandom);
        else if (gen_fill == 0 && r < 9) add_op(OP_DEQUEUE, $urandom, $urandom);
        else add_op(OP_DISCARD, $urandom, $urandom_range(gen_fill, Depth - 1));
      end else if ((gen_fill < target) ? (r < 80) : (r < 30)) begin
        add_op(OP_ENQUEUE, rand_word(), $urandom);
      end else if (gen_fill == 0) begin
        add_op(OP_ENQUEUE, rand_word(), $urandom);
      end else if (r % 3 == 0) begin
        add_op(OP_DEQUEUE, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: pos = 0;
          1: pos = gen_fill - 1;
          default: pos = $urandom_range(0, gen_fill - 1);
        endcase
        add_op(OP_DISCARD, $urandom, pos);
      end
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || expected_status.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("** fifo_with_indexed_discard: PASSED **");
    end else begin
      $display("** fifo_with_indexed_discard: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fwid_pkg.sv
rtl/fwid_if.sv
rtl/fwid_cell.sv
rtl/fifo_with_indexed_discard.sv
tb/testbench.sv
